### sv/eul_pkg.sv
// eul_pkg: shared types, constants and tables of the Euler rotation composer.
// No dependencies; imported by the request and response interfaces and all modules.
package eul_pkg;

   localparam int TRIG_LAT = 16;
   localparam int MMUL_LAT = 2;
   localparam int PIPE_LAT = TRIG_LAT + 3 * MMUL_LAT;
   localparam int SERIES_TERMS = 6;
   localparam int RED_STEPS = 5;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;

   // reduction thresholds quarter_pi + j * half_pi (Q30)
   localparam logic signed [34:0] RED_HI [RED_STEPS] = '{
      35'sd843314857, 35'sd2529944570, 35'sd4216574283,
      35'sd5903203996, 35'sd7589833709};
   // k * half_pi (Q30)
   localparam logic signed [34:0] K_HALF_PI [RED_STEPS + 1] = '{
      35'sd0, 35'sd1686629713, 35'sd3373259426,
      35'sd5059889139, 35'sd6746518852, 35'sd8433148565};

   // series divisors as reciprocal multiply: floor(x / d) = (x * M) >> S for x < 2^31
   localparam logic [31:0] SIN_MUL [SERIES_TERMS] = '{
      32'((64'd1 << 39) / 156 + 1), 32'((64'd1 << 38) / 110 + 1),
      32'((64'd1 << 38) / 72 + 1),  32'((64'd1 << 37) / 42 + 1),
      32'((64'd1 << 36) / 20 + 1),  32'((64'd1 << 34) / 6 + 1)};
   localparam int SIN_SHIFT [SERIES_TERMS] = '{39, 38, 38, 37, 36, 34};
   localparam logic [31:0] COS_MUL [SERIES_TERMS] = '{
      32'((64'd1 << 39) / 132 + 1), 32'((64'd1 << 38) / 90 + 1),
      32'((64'd1 << 37) / 56 + 1),  32'((64'd1 << 36) / 30 + 1),
      32'((64'd1 << 35) / 12 + 1),  32'((64'd1 << 32) / 2 + 1)};
   localparam int COS_SHIFT [SERIES_TERMS] = '{39, 38, 37, 36, 35, 32};

   typedef logic [2:0][2:0][15:0] mat_type;

   typedef struct packed {
      logic [29:0] s;
      logic [29:0] s2;
      logic        neg;
      logic [1:0]  quad;
   } trig_side_type;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
      logic               saturated;
   } rsp_type;

endpackage

### sv/eul_if.sv
// eul_if: valid/ready channel interfaces for request, response and CSR write.
// Depends on eul_pkg.
interface eul_req_if import eul_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface eul_rsp_if import eul_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface eul_csr_if ();
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/eul_trig.sv
// eul_trig: pipelined sine/cosine of one Q4.12 angle, Q1.14 results.
// Depends on eul_pkg. The pipeline advances when en is high.
module eul_trig import eul_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] angle,
   output logic signed [15:0] sin_out,
   output logic signed [15:0] cos_out
);

   logic signed [34:0] r;
   logic signed [34:0] rr;
   logic [2:0]         kpos;
   logic [2:0]         kneg;
   logic [34:0]        rmag;
   trig_side_type      side_a_in;
   trig_side_type      side_a_ff;
   trig_side_type      side_b_ff;

   logic [29:0]   xs_ff [SERIES_TERMS];
   logic [29:0]   xc_ff [SERIES_TERMS];
   logic [30:0]   tsd_ff [SERIES_TERMS];
   logic [30:0]   tcd_ff [SERIES_TERMS];
   trig_side_type side_p_ff [SERIES_TERMS];
   trig_side_type side_d_ff [SERIES_TERMS];

   logic [29:0] sv_ff;
   logic [30:0] tc_ff;
   logic        neg_ff;
   logic [1:0]  quad_ff;
   logic signed [15:0] sin_ff;
   logic signed [15:0] cos_ff;

   function automatic logic signed [15:0] rnd16(input logic [30:0] mag, input logic ng);
      logic [15:0] q;
      q = 16'((32'(mag) + 32'd32768) >> 16);
      return ng ? 16'(-q) : q;
   endfunction

   // range reduction by multiples of half pi
   always_comb begin
      r = {angle[15], angle, 18'd0};
      kpos = '0;
      kneg = '0;
      for (int j = 0; j < RED_STEPS; j++) begin
         if (r > RED_HI[j]) kpos = kpos + 3'd1;
         if (r < -RED_HI[j]) kneg = kneg + 3'd1;
      end
      rr = (kneg != 3'd0) ? r + K_HALF_PI[kneg] : r - K_HALF_PI[kpos];
      rmag = rr[34] ? 35'(-rr) : 35'(rr);
      side_a_in.s = rmag[29:0];
      side_a_in.s2 = '0;
      side_a_in.neg = rr[34];
      side_a_in.quad = (kneg != 3'd0) ? 2'(3'd0 - kneg) : kpos[1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff <= side_a_in;
         side_b_ff.s <= side_a_ff.s;
         side_b_ff.s2 <= 30'((60'(side_a_ff.s) * 60'(side_a_ff.s)) >> 30);
         side_b_ff.neg <= side_a_ff.neg;
         side_b_ff.quad <= side_a_ff.quad;
      end
   end

   for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_iter
      logic [30:0]   ts_prev;
      logic [30:0]   tc_prev;
      trig_side_type side_prev;
      if (i == 0) begin : g_first
         assign ts_prev = Q30_ONE;
         assign tc_prev = Q30_ONE;
         assign side_prev = side_b_ff;
      end else begin : g_next
         assign ts_prev = tsd_ff[i-1];
         assign tc_prev = tcd_ff[i-1];
         assign side_prev = side_d_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            xs_ff[i] <= 30'((61'(side_prev.s2) * 61'(ts_prev)) >> 30);
            xc_ff[i] <= 30'((61'(side_prev.s2) * 61'(tc_prev)) >> 30);
            side_p_ff[i] <= side_prev;
            tsd_ff[i] <= Q30_ONE - 31'((62'(xs_ff[i]) * 62'(SIN_MUL[i])) >> SIN_SHIFT[i]);
            tcd_ff[i] <= Q30_ONE - 31'((62'(xc_ff[i]) * 62'(COS_MUL[i])) >> COS_SHIFT[i]);
            side_d_ff[i] <= side_p_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sv_ff <= 30'((61'(side_d_ff[SERIES_TERMS-1].s) * 61'(tsd_ff[SERIES_TERMS-1])) >> 30);
         tc_ff <= tcd_ff[SERIES_TERMS-1];
         neg_ff <= side_d_ff[SERIES_TERMS-1].neg;
         quad_ff <= side_d_ff[SERIES_TERMS-1].quad;
      end
   end

   // quadrant restore, then round to Q1.14
   always_ff @(posedge clock) begin
      if (en) begin
         case (quad_ff)
            2'd0: begin
               sin_ff <= rnd16({1'b0, sv_ff}, neg_ff);
               cos_ff <= rnd16(tc_ff, 1'b0);
            end
            2'd1: begin
               sin_ff <= rnd16(tc_ff, 1'b0);
               cos_ff <= rnd16({1'b0, sv_ff}, !neg_ff);
            end
            2'd2: begin
               sin_ff <= rnd16({1'b0, sv_ff}, !neg_ff);
               cos_ff <= rnd16(tc_ff, 1'b1);
            end
            default: begin
               sin_ff <= rnd16(tc_ff, 1'b1);
               cos_ff <= rnd16({1'b0, sv_ff}, neg_ff);
            end
         endcase
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

### sv/eul_mmul.sv
// eul_mmul: two-stage 3x3 Q1.14 matrix product with rounding and saturation.
// Depends on eul_pkg. Both stages advance when en is high.
module eul_mmul import eul_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  mat_type a,
   input  mat_type b,
   input  logic    sat_in,
   output mat_type p,
   output logic    sat_out
);

   logic signed [31:0] prod_ff [3][3][3];
   logic               sat1_ff;
   mat_type            p_in;
   logic               sat_in2;
   mat_type            p_ff;
   logic               sat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 3; k++)
                  prod_ff[i][j][k] <= 32'($signed(a[i][k])) * 32'($signed(b[k][j]));
         sat1_ff <= sat_in;
      end
   end

   // sum, round half away from zero, clamp
   always_comb begin
      logic signed [33:0] acc;
      logic [33:0]        mag;
      logic [19:0]        q;
      sat_in2 = sat1_ff;
      p_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = 34'(prod_ff[i][j][0]) + 34'(prod_ff[i][j][1]) + 34'(prod_ff[i][j][2]);
            mag = acc[33] ? 34'(-acc) : 34'(acc);
            q = 20'((mag + 34'd8192) >> 14);
            if (!acc[33] && q > 20'd32767) begin
               p_in[i][j] = 16'h7fff;
               sat_in2 = 1'b1;
            end else if (acc[33] && q > 20'd32768) begin
               p_in[i][j] = 16'h8000;
               sat_in2 = 1'b1;
            end else begin
               p_in[i][j] = acc[33] ? 16'(-q) : q[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
         sat_ff <= sat_in2;
      end
   end

   assign p = p_ff;
   assign sat_out = sat_ff;

endmodule

### sv/euler_rotation_compose.sv
// euler_rotation_compose: applies Rz, Ry, Rx built from three angles to a
// 3x3 Q1.14 matrix. Depends on eul_pkg, eul_if, eul_trig, eul_mmul.
//
// Usage:
//   req_ch carries three Q4.12 angles and the input matrix; rsp_ch returns
//   the composed matrix and a saturated flag, one response per request.
//   csr_ch writes compose_global (0: M*Rz*Ry*Rx, 1: Rx*Ry*Rz*M); it is
//   always ready and must be written only while no request is in flight.
// Timing:
//   The sine/cosine pipeline (six series terms, a multiply and a reciprocal
//   divide each) is followed by the three matrix products. One request is
//   accepted every cycle while the pipeline does not hold (see Backpressure).
// Reset:
//   Synchronous, active high; clears the valid bits and sets local mode.
// Backpressure:
//   The whole pipeline holds while a response waits in the output register
//   and rsp_ch.ready is low; req_ch.ready is low for those cycles. Bubbles
//   inside the pipeline are not squeezed out while it holds.
module euler_rotation_compose import eul_pkg::*; (
   input logic       clock,
   input logic       reset,
   eul_req_if.sink   req_ch,
   eul_rsp_if.source rsp_ch,
   eul_csr_if.sink   csr_ch
);

   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;
   logic                compose_global_ff;
   mat_type             m_in;
   mat_type             m_dly_ff [TRIG_LAT];
   logic signed [15:0]  sx, cx, sy, cy, sz, cz;
   mat_type             rx, ry, rz, m_t;
   mat_type             a1, b1, b2, b3;
   mat_type             b2_dly_ff [MMUL_LAT];
   mat_type             b3_dly_ff [2 * MMUL_LAT];
   mat_type             p1, p2, p3;
   logic                sat1, sat2, sat3;

   assign en = !vld_ff[PIPE_LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         compose_global_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         compose_global_ff <= csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_ch.valid};
      end
   end

   always_comb begin
      m_in[0][0] = req_ch.data.m00;
      m_in[0][1] = req_ch.data.m01;
      m_in[0][2] = req_ch.data.m02;
      m_in[1][0] = req_ch.data.m10;
      m_in[1][1] = req_ch.data.m11;
      m_in[1][2] = req_ch.data.m12;
      m_in[2][0] = req_ch.data.m20;
      m_in[2][1] = req_ch.data.m21;
      m_in[2][2] = req_ch.data.m22;
   end

   // matrix rides alongside the trig pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         m_dly_ff[0] <= m_in;
         for (int i = 1; i < TRIG_LAT; i++) m_dly_ff[i] <= m_dly_ff[i-1];
      end
   end

   eul_trig u_trig_x (.clock, .en, .angle(req_ch.data.angle_x), .sin_out(sx), .cos_out(cx));
   eul_trig u_trig_y (.clock, .en, .angle(req_ch.data.angle_y), .sin_out(sy), .cos_out(cy));
   eul_trig u_trig_z (.clock, .en, .angle(req_ch.data.angle_z), .sin_out(sz), .cos_out(cz));

   always_comb begin
      m_t = m_dly_ff[TRIG_LAT-1];
      rx = '0;
      ry = '0;
      rz = '0;
      rx[0][0] = Q14_ONE;
      rx[1][1] = cx;
      rx[1][2] = 16'(-sx);
      rx[2][1] = sx;
      rx[2][2] = cx;
      ry[1][1] = Q14_ONE;
      ry[0][0] = cy;
      ry[0][2] = sy;
      ry[2][0] = 16'(-sy);
      ry[2][2] = cy;
      rz[2][2] = Q14_ONE;
      rz[0][0] = cz;
      rz[0][1] = 16'(-sz);
      rz[1][0] = sz;
      rz[1][1] = cz;
      a1 = compose_global_ff ? rx : m_t;
      b1 = compose_global_ff ? ry : rz;
      b2 = compose_global_ff ? rz : ry;
      b3 = compose_global_ff ? m_t : rx;
   end

   // later operands wait for the running product
   always_ff @(posedge clock) begin
      if (en) begin
         b2_dly_ff[0] <= b2;
         for (int i = 1; i < MMUL_LAT; i++) b2_dly_ff[i] <= b2_dly_ff[i-1];
         b3_dly_ff[0] <= b3;
         for (int i = 1; i < 2 * MMUL_LAT; i++) b3_dly_ff[i] <= b3_dly_ff[i-1];
      end
   end

   eul_mmul u_mmul_1 (.clock, .en, .a(a1), .b(b1), .sat_in(1'b0), .p(p1), .sat_out(sat1));
   eul_mmul u_mmul_2 (.clock, .en, .a(p1), .b(b2_dly_ff[MMUL_LAT-1]), .sat_in(sat1),
                      .p(p2), .sat_out(sat2));
   eul_mmul u_mmul_3 (.clock, .en, .a(p2), .b(b3_dly_ff[2*MMUL_LAT-1]), .sat_in(sat2),
                      .p(p3), .sat_out(sat3));

   assign rsp_ch.valid = vld_ff[PIPE_LAT-1];
   assign rsp_ch.data.r00 = p3[0][0];
   assign rsp_ch.data.r01 = p3[0][1];
   assign rsp_ch.data.r02 = p3[0][2];
   assign rsp_ch.data.r10 = p3[1][0];
   assign rsp_ch.data.r11 = p3[1][1];
   assign rsp_ch.data.r12 = p3[1][2];
   assign rsp_ch.data.r20 = p3[2][0];
   assign rsp_ch.data.r21 = p3[2][1];
   assign rsp_ch.data.r22 = p3[2][2];
   assign rsp_ch.data.saturated = sat3;

endmodule
